FILE: rtl/sorted_bookmark_table_insert_macros.svh
// ---------------------------------------------------------------------------
// Sorted bookmark table insert: assertion macros
// Concurrent checks; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SORTED_BOOKMARK_TABLE_INSERT_MACROS_SVH
`define SORTED_BOOKMARK_TABLE_INSERT_MACROS_SVH

`ifndef SYNTH
// Holds on every edge out of reset.
`define SBT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define SBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/sbt_pkg.sv
// ---------------------------------------------------------------------------
// Sorted bookmark table: shared package
// Table sizing, beat types and the back-end status bundle.
// ---------------------------------------------------------------------------
package sbt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PAGE_W      = 16;
    localparam int OFF_W       = 32;
    localparam int ENT_W       = 5;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic [OFF_W-1:0]  byte_offset;
    } t_in_beat;

    typedef struct packed {
        logic             status;
        logic             evicted;
        logic [ENT_W-1:0] entry_count;
    } t_out_beat;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } t_back_stat;

endpackage

FILE: rtl/sorted_bookmark_table_insert.sv
// ---------------------------------------------------------------------------
// Sorted bookmark table insert: top level
// Keeps bookmarks in ascending page order; refuses duplicate pages and, when full, drops entry 0 (the lowest page).
// ---------------------------------------------------------------------------
// Request channel: drive i_item and raise push; the beat is taken on an edge
// where push is high and full is low. A two-entry front queue holds beats.
// Result channel: while empty is low, o_result holds the oldest result;
// it leaves on an edge where pop is high. Exactly one result per request.
// Steps: a taken request waits in the front queue until the back end is
// idle and loads it; the back end then compares one stored page per cycle
// (stopping early on a match; the walk is skipped when the table is empty),
// and in its final step writes the table as it pushes the result, which is
// registered in the result queue. The back end takes one request at a time,
// loading a new one only after pushing the last result; the table walk sets
// the rate.
// Reset clears the entry count and both queues; table contents are left
// as they are, since only entries below the count are ever read.
// If the receiver stalls, the two-entry result queue fills, the back end
// waits in its final step, and then the front queue backs up to full.
// ---------------------------------------------------------------------------
`include "sorted_bookmark_table_insert_macros.svh"

module sorted_bookmark_table_insert
    import sbt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_beat  i_item,
    output logic      full,
    input  logic      pop,
    output t_out_beat o_result,
    output logic      empty
);

    // front queue -> back end
    t_in_beat   w_req;
    logic       w_req_empty;
    logic       w_req_pop;

    // back end -> result queue
    t_out_beat  w_res;
    logic       w_res_push;
    logic       w_res_full;
    t_back_stat w_stat;

    sbt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_pop   (w_req_pop),
        .o_item  (w_req),
        .o_empty (w_req_empty)
    );

    // Walk-and-insert engine; owns the sorted table and the entry count.
    sbt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_empty (w_req_empty),
        .i_req       (w_req),
        .o_req_pop   (w_req_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .o_stat      (w_stat)
    );

    sbt_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_res   (o_result),
        .o_empty (empty)
    );

    // ---- checks ----
    `SBT_ASSERT(a_cnt_max, i_clk, i_rst_n, w_stat.count <= CNT_W'(TABLE_DEPTH), "count overflow")
    `SBT_ASSERT_IMP(a_dup_no_evict, i_clk, i_rst_n, !empty && o_result.status, !o_result.evicted, "refused beat marked evicted")
    `SBT_ASSERT_IMP(a_push_busy, i_clk, i_rst_n, w_res_push, w_stat.busy && !w_res_full, "result pushed while idle or queue full")
    `SBT_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !w_res_push, $stable(w_stat.count), "count moved without a result")

endmodule

FILE: rtl/sbt_front.sv
// ---------------------------------------------------------------------------
// Sorted bookmark table: front queue
// Two-entry queue that takes request beats and hands them to the back end.
// ---------------------------------------------------------------------------
module sbt_front
    import sbt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_beat i_item,
    output logic     o_full,
    input  logic     i_pop,
    output t_in_beat o_item,
    output logic     o_empty
);

    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_in_beat   r_mem [2];
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

FILE: rtl/sbt_res_q.sv
// ---------------------------------------------------------------------------
// Sorted bookmark table: result queue
// Two-entry queue holding result beats until the receiver pops them.
// ---------------------------------------------------------------------------
module sbt_res_q
    import sbt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_beat i_res,
    output logic      o_full,
    input  logic      i_pop,
    output t_out_beat o_res,
    output logic      o_empty
);

    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_out_beat  r_mem [2];
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

endmodule

FILE: rtl/sbt_back.sv
// ---------------------------------------------------------------------------
// Sorted bookmark table: back end
// Walks the sorted table one entry per cycle, then inserts or refuses.
// ---------------------------------------------------------------------------
module sbt_back
    import sbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_empty,
    input  t_in_beat   i_req,
    output logic       o_req_pop,
    input  logic       i_res_full,
    output logic       o_res_push,
    output t_out_beat  o_res,
    output t_back_stat o_stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [PAGE_W-1:0] r_pg;
    logic [OFF_W-1:0]  r_off;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [CNT_W-1:0]  r_less;
    logic [CNT_W-1:0]  n_less;
    logic              r_dup;
    logic              n_dup;
    logic [CNT_W-1:0]  r_count;
    logic [PAGE_W-1:0] r_pages [TABLE_DEPTH];
    logic [OFF_W-1:0]  r_offs  [TABLE_DEPTH];

    logic [PAGE_W-1:0] w_rd_pg;
    logic              w_eq;
    logic              w_lt;
    logic              w_last;
    logic              w_tbl_full;
    logic [CNT_W-1:0]  w_pos;
    logic              w_apply;
    logic              w_load;

    assign w_rd_pg    = r_pages[r_idx];
    assign w_eq       = (w_rd_pg == r_pg);
    assign w_lt       = (w_rd_pg < r_pg);
    assign w_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_tbl_full = (r_count == CNT_W'(TABLE_DEPTH));
    // Entry 0 is the lowest page; dropping it removes one "less" hit if any.
    assign w_pos      = r_less - CNT_W'(w_tbl_full && (r_less != '0));

    assign w_load     = (r_state == ST_IDLE) && !i_req_empty;
    assign o_req_pop  = w_load;
    assign o_res_push = (r_state == ST_FINISH) && !i_res_full;
    assign w_apply    = o_res_push && !r_dup;

    always_comb begin
        o_res.status      = r_dup;
        o_res.evicted     = !r_dup && w_tbl_full;
        if (r_dup || w_tbl_full) begin
            o_res.entry_count = ENT_W'(r_count);
        end else begin
            o_res.entry_count = ENT_W'(r_count + CNT_W'(1));
        end
    end

    assign o_stat.busy  = (r_state != ST_IDLE);
    assign o_stat.count = r_count;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_less  = r_less;
        n_dup   = r_dup;
        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_idx   = '0;
                    n_less  = '0;
                    n_dup   = 1'b0;
                    n_state = (r_count == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_dup  = w_eq;
                n_less = r_less + CNT_W'(w_lt);
                n_idx  = r_idx + 1'b1;
                if (w_eq || w_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (o_res_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_apply && !w_tbl_full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_less <= n_less;
        r_dup  <= n_dup;
        if (w_load) begin
            r_pg  <= i_req.page_number;
            r_off <= i_req.byte_offset;
        end
    end

    // Per-cell update: when full, entries below the slot slide down one;
    // otherwise entries above the slot slide up one.
    for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
        logic [PAGE_W-1:0] w_pg_up;
        logic [OFF_W-1:0]  w_off_up;
        logic [PAGE_W-1:0] w_pg_dn;
        logic [OFF_W-1:0]  w_off_dn;

        if (j < TABLE_DEPTH - 1) begin : g_up
            assign w_pg_up  = r_pages[j+1];
            assign w_off_up = r_offs[j+1];
        end else begin : g_top
            assign w_pg_up  = r_pages[j];
            assign w_off_up = r_offs[j];
        end

        if (j > 0) begin : g_dn
            assign w_pg_dn  = r_pages[j-1];
            assign w_off_dn = r_offs[j-1];
        end else begin : g_bot
            assign w_pg_dn  = r_pages[j];
            assign w_off_dn = r_offs[j];
        end

        always_ff @(posedge i_clk) begin
            if (w_apply) begin
                if (CNT_W'(j) == w_pos) begin
                    r_pages[j] <= r_pg;
                    r_offs[j]  <= r_off;
                end else if (w_tbl_full && (CNT_W'(j) < w_pos)) begin
                    r_pages[j] <= w_pg_up;
                    r_offs[j]  <= w_off_up;
                end else if (!w_tbl_full && (CNT_W'(j) > w_pos)) begin
                    r_pages[j] <= w_pg_dn;
                    r_offs[j]  <= w_off_dn;
                end
            end
        end
    end

endmodule
